[hw/rtl/epd_pkg.sv]
// ----------------------------------------------------------------------------
// epd_pkg: shared types and constants for echo pulse ranging
// Register indexes, field widths and the controller/datapath links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epd_pkg;

  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int PULSE_WIDTH    = 16;
  localparam int SPEED_WIDTH    = 12;
  localparam int DIST_WIDTH     = 28;
  localparam int CM_WIDTH       = 8;
  localparam int DUTY_WIDTH     = 16;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_COUNTER_TOP  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HALF_SPEED   = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_DISTANCE = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DUTY_GAIN    = 2'd3;

  localparam logic [PULSE_WIDTH-1:0] RESET_COUNTER_TOP  = 16'd65535;
  localparam logic [SPEED_WIDTH-1:0] RESET_HALF_SPEED   = 12'd1114;
  localparam logic [CM_WIDTH-1:0]    RESET_MAX_DISTANCE = 8'd30;
  localparam logic [CM_WIDTH-1:0]    RESET_DUTY_GAIN    = 8'd30;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic step;      // accept one tick transaction
    logic mul_en;    // form the distance product
    logic out_load;  // load the result registers
  } epd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pulse_end; // the offered tick ends a pulse
  } epd_status_t;

endpackage

[hw/rtl/epd_datapath.sv]
// ----------------------------------------------------------------------------
// epd_datapath: counter, edge capture and ranging arithmetic
// Holds the configuration, the tick counter, edge state and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epd_datapath #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [epd_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [epd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                echo_level,
  input  epd_pkg::epd_cmd_t                   cmd,
  output epd_pkg::epd_status_t                status,
  output logic [epd_pkg::PULSE_WIDTH-1:0]     pulse_ticks,
  output logic [epd_pkg::DIST_WIDTH-1:0]      distance_q16,
  output logic                                in_range,
  output logic [epd_pkg::DUTY_WIDTH-1:0]      duty_value
);

  logic [epd_pkg::PULSE_WIDTH-1:0] counter_top;
  logic [epd_pkg::SPEED_WIDTH-1:0] half_speed_q16;
  logic [epd_pkg::CM_WIDTH-1:0]    max_distance_cm;
  logic [epd_pkg::CM_WIDTH-1:0]    duty_gain;

  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] rise_time;
  logic                   last_level;
  logic                   waiting_fall;

  logic [epd_pkg::PULSE_WIDTH-1:0] width_reg;
  logic [epd_pkg::DIST_WIDTH-1:0]  dist_reg;

  logic [COUNT_WIDTH-1:0]          top;
  logic [COUNT_WIDTH-1:0]          width_cw;
  logic [COUNT_WIDTH-1:0]          tick_count_next;
  logic                            rise_seen;
  logic                            fall_seen;
  logic                            range_ok;
  logic [epd_pkg::CM_WIDTH-1:0]    remain_cm;
  logic [epd_pkg::DUTY_WIDTH-1:0]  duty_next;

  always_comb begin
    top       = COUNT_WIDTH'(counter_top);
    rise_seen = echo_level && !last_level && !waiting_fall;
    fall_seen = !echo_level && last_level && waiting_fall;
    if (rise_time <= tick_count) begin
      width_cw = tick_count - rise_time;
    end else begin
      width_cw = top + COUNT_WIDTH'(1) - rise_time + tick_count;
    end
    if (tick_count >= top) begin
      tick_count_next = '0;
    end else begin
      tick_count_next = tick_count + COUNT_WIDTH'(1);
    end
    status.pulse_end = fall_seen;
  end

  // Range test and duty from the registered distance
  always_comb begin
    range_ok  = dist_reg <= {4'd0, max_distance_cm, 16'd0};
    remain_cm = max_distance_cm - dist_reg[23:16];
    duty_next = range_ok ? (16'(remain_cm) * 16'(duty_gain)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_top     <= epd_pkg::RESET_COUNTER_TOP;
      half_speed_q16  <= epd_pkg::RESET_HALF_SPEED;
      max_distance_cm <= epd_pkg::RESET_MAX_DISTANCE;
      duty_gain       <= epd_pkg::RESET_DUTY_GAIN;
      tick_count      <= '0;
      rise_time       <= '0;
      last_level      <= 1'b0;
      waiting_fall    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          epd_pkg::REG_COUNTER_TOP:  counter_top     <= cfg_data;
          epd_pkg::REG_HALF_SPEED:   half_speed_q16  <= cfg_data[epd_pkg::SPEED_WIDTH-1:0];
          epd_pkg::REG_MAX_DISTANCE: max_distance_cm <= cfg_data[epd_pkg::CM_WIDTH-1:0];
          epd_pkg::REG_DUTY_GAIN:    duty_gain       <= cfg_data[epd_pkg::CM_WIDTH-1:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        if (rise_seen) begin
          rise_time    <= tick_count;
          waiting_fall <= 1'b1;
        end else if (fall_seen) begin
          waiting_fall <= 1'b0;
        end
        last_level <= echo_level;
        tick_count <= tick_count_next;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (cmd.step && fall_seen) begin
      width_reg <= epd_pkg::PULSE_WIDTH'(width_cw);
    end
    if (cmd.mul_en) begin
      dist_reg <= 28'(width_reg) * 28'(half_speed_q16);
    end
    if (cmd.out_load) begin
      pulse_ticks  <= width_reg;
      distance_q16 <= dist_reg;
      in_range     <= range_ok;
      duty_value   <= duty_next;
    end
  end

endmodule

[hw/rtl/epd_controller.sv]
// ----------------------------------------------------------------------------
// epd_controller: sequencing of tick transactions and result delivery
// Steps the datapath per tick, runs the two arithmetic steps, owns out_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epd_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  epd_pkg::epd_status_t status,
  output epd_pkg::epd_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DUTY
  } state_t;

  state_t state;
  logic   out_free;

  always_comb begin
    in_ready     = (state == ST_IDLE);
    out_free     = !out_valid || out_ready;
    cmd.step     = in_valid && in_ready;
    cmd.mul_en   = (state == ST_MUL);
    cmd.out_load = (state == ST_DUTY) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.step && status.pulse_end) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DUTY;
        end
        ST_DUTY: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/echo_pulse_ranging_to_duty.sv]
// ----------------------------------------------------------------------------
// echo_pulse_ranging_to_duty: ultrasonic echo width to distance and duty
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Each input transaction is one timer tick carrying the echo pin level. A
// tick that does not end a pulse leaves the controller idle, so such ticks
// stream at one per clock. A tick whose falling edge ends a pulse holds
// in_ready low while the datapath forms the distance product, then the
// range test and duty product; the duty step stretches for as long as an
// earlier result still waits on the output. Results are held in an output
// register, so new ticks are taken while a result waits to be collected.
// Configuration writes take effect on the clock edge where cfg_wen is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module echo_pulse_ranging_to_duty #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [epd_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [epd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                echo_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [epd_pkg::PULSE_WIDTH-1:0]     pulse_ticks,
  output logic [epd_pkg::DIST_WIDTH-1:0]      distance_q16,
  output logic                                in_range,
  output logic [epd_pkg::DUTY_WIDTH-1:0]      duty_value
);

  // Command and status links between control and datapath
  epd_pkg::epd_cmd_t    cmd;
  epd_pkg::epd_status_t status;

  // Sequence tick transactions, arithmetic steps and result hand-off
  epd_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold configuration, advance the tick counter, capture edges, compute
  epd_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .echo_level   (echo_level),
    .cmd          (cmd),
    .status       (status),
    .pulse_ticks  (pulse_ticks),
    .distance_q16 (distance_q16),
    .in_range     (in_range),
    .duty_value   (duty_value)
  );

endmodule

[hw/rtl/epd_checker.sv]
// ----------------------------------------------------------------------------
// epd_checker: port-level assertions for echo pulse ranging
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [epd_pkg::PULSE_WIDTH-1:0] pulse_ticks,
  input logic [epd_pkg::DIST_WIDTH-1:0]  distance_q16,
  input logic                            in_range,
  input logic [epd_pkg::DUTY_WIDTH-1:0]  duty_value
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pulse_ticks)
      && $stable(distance_q16) && $stable(duty_value))
    else $error("stalled result changed");

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Out of range gives zero duty
  a_zero_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> duty_value == '0)
    else $error("nonzero duty out of range");

  // In range means the distance stays below 256 cm
  a_range_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_range |-> distance_q16[27:24] == 4'd0)
    else $error("in range with distance above limit field");

endmodule

bind echo_pulse_ranging_to_duty epd_checker u_epd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .pulse_ticks  (pulse_ticks),
  .distance_q16 (distance_q16),
  .in_range     (in_range),
  .duty_value   (duty_value)
);

[tb/echo_pulse_ranging_to_duty_test.sv]
// ----------------------------------------------------------------------------
// echo_pulse_ranging_to_duty_test: self-checking bench for echo ranging
// Streams echo level ticks through the block. A built-in model of the counter
// and edge capture predicts readings not typed in. The bench starts with a
// short table of directed ticks and register writes, then runs random pulse
// trains under several register settings. Both handshakes idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module echo_pulse_ranging_to_duty_test;

  localparam int          CLK_PERIOD      = 12;
  localparam int          RESET_CYCLES    = 6;
  // A pulse-ending tick occupies the block while the result forms; leave margin.
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          PHASE_COUNT     = 6;
  localparam int          TICKS_PER_PHASE = 60;
  localparam longint      TIMEOUT_NS      = 64'd60_000_000;

  typedef logic [epd_pkg::CFG_IDX_WIDTH-1:0] reg_idx_t;

  // One pulse reading as the block reports it
  typedef struct packed {
    logic [epd_pkg::PULSE_WIDTH-1:0] pulse_ticks;
    logic [epd_pkg::DIST_WIDTH-1:0]  distance_q16;
    logic                            in_range;
    logic [epd_pkg::DUTY_WIDTH-1:0]  duty_value;
  } echo_reading_t;

  // One row of the directed table: a register write, or a run of ticks
  typedef struct {
    logic          is_write;
    reg_idx_t      reg_idx;
    logic [15:0]   reg_value;
    logic          level;
    int unsigned   run;
    logic          known;     // reading typed in below, not predicted
    echo_reading_t reading;
  } plan_row_t;

  // --------------------------------------------------------------------------
  // Block ports; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic                               clk        = 1'b0;
  logic                               rst        = 1'b1;
  logic                               cfg_wen    = 1'b0;
  reg_idx_t                           cfg_index  = '0;
  logic [epd_pkg::CFG_DATA_WIDTH-1:0] cfg_data   = '0;
  logic                               in_valid   = 1'b0;
  logic                               in_ready;
  logic                               echo_level = 1'b0;
  logic                               out_valid;
  logic                               out_ready  = 1'b0;
  logic [epd_pkg::PULSE_WIDTH-1:0]    pulse_ticks;
  logic [epd_pkg::DIST_WIDTH-1:0]     distance_q16;
  logic                               in_range;
  logic [epd_pkg::DUTY_WIDTH-1:0]     duty_value;

  echo_pulse_ranging_to_duty i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .echo_level   (echo_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pulse_ticks  (pulse_ticks),
    .distance_q16 (distance_q16),
    .in_range     (in_range),
    .duty_value   (duty_value)
  );

  // --------------------------------------------------------------------------
  // Ranging model: register copies and counter/edge state
  // --------------------------------------------------------------------------
  logic [epd_pkg::PULSE_WIDTH-1:0] top_cfg    = epd_pkg::RESET_COUNTER_TOP;
  logic [epd_pkg::SPEED_WIDTH-1:0] speed_cfg  = epd_pkg::RESET_HALF_SPEED;
  logic [epd_pkg::CM_WIDTH-1:0]    limit_cfg  = epd_pkg::RESET_MAX_DISTANCE;
  logic [epd_pkg::CM_WIDTH-1:0]    gain_cfg   = epd_pkg::RESET_DUTY_GAIN;

  logic [15:0]            tick_cnt   = '0;
  logic                   prev_level = 1'b0;
  logic                   in_pulse   = 1'b0;
  logic [15:0]            rise_cnt   = '0;

  echo_reading_t          awaited_readings[$];

  int unsigned ticks_sent     = 0;
  int unsigned readings_seen  = 0;
  int unsigned near_readings  = 0;
  int unsigned far_readings   = 0;
  int unsigned wrapped_pulses = 0;
  int unsigned reg_writes     = 0;
  int unsigned errors         = 0;
  int unsigned burst_left     = 0;

  // Advance the model by one accepted tick; return 1 when a pulse ends.
  function automatic logic measure_echo_tick(input logic lvl, output echo_reading_t r);
    logic [15:0] now;
    logic [16:0] span;
    logic [11:0] room;
    logic [19:0] duty_full;
    logic        done;
    now  = tick_cnt;
    done = 1'b0;
    r    = '0;
    if (lvl && !prev_level && !in_pulse) begin
      rise_cnt = now;
      in_pulse = 1'b1;
    end else if (!lvl && prev_level && in_pulse) begin
      if (rise_cnt <= now) begin
        r.pulse_ticks = now - rise_cnt;
      end else begin
        // Pulse spans the counter wrap: the period is top + 1
        span          = {1'b0, top_cfg} + 17'd1 - {1'b0, rise_cnt} + {1'b0, now};
        r.pulse_ticks = span[15:0];
        wrapped_pulses++;
      end
      r.distance_q16 = epd_pkg::DIST_WIDTH'(r.pulse_ticks)
                       * epd_pkg::DIST_WIDTH'(speed_cfg);
      r.in_range     = (r.distance_q16 <= {limit_cfg, 16'h0000});
      if (r.in_range) begin
        room         = {4'h0, limit_cfg} - r.distance_q16[27:16];
        duty_full    = room * gain_cfg;
        r.duty_value = duty_full[15:0];
      end
      in_pulse = 1'b0;
      done     = 1'b1;
    end
    prev_level = lvl;
    // A count at or above top (top may have just been lowered) wraps to zero
    tick_cnt = (now >= top_cfg) ? 16'd0 : now + 16'd1;
    return done;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Receiver: out_ready follows a rotating pattern, reloaded at random times.
  // Fixed patterns range from always ready to one cycle in sixteen, or random.
  // --------------------------------------------------------------------------
  logic [15:0] ready_pat  = 16'hFFFF;
  int unsigned pat_cycles = 0;

  always @(negedge clk) begin
    if (pat_cycles == 0) begin
      pat_cycles = $urandom_range(8, 48);
      case ($urandom_range(0, 4))
        0, 1:    ready_pat = 16'hFFFF;
        2:       ready_pat = 16'h8000;
        3:       ready_pat = 16'h0101;
        default: ready_pat = $urandom;
      endcase
    end
    out_ready <= ready_pat[0];
    ready_pat  = {ready_pat[0], ready_pat[15:1]};
    pat_cycles--;
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each transaction against the oldest expectation
  // --------------------------------------------------------------------------
  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    echo_reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_readings.size() == 0) begin
        errors++;
        $display("%0t: reading with none expected, actual %0d/%0d/%0d/%0d", $time,
                 pulse_ticks, distance_q16, in_range, duty_value);
      end else begin
        want = awaited_readings.pop_front();
        readings_seen++;
        if (want.in_range) near_readings++;
        else               far_readings++;
        report_field("pulse_ticks",  32'(want.pulse_ticks),  32'(pulse_ticks));
        report_field("distance_q16", 32'(want.distance_q16), 32'(distance_q16));
        report_field("in_range",     32'(want.in_range),     32'(in_range));
        report_field("duty_value",   32'(want.duty_value),   32'(duty_value));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: bursts of back-to-back transactions with random gaps between
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic lvl, input logic known, input echo_reading_t typed);
    echo_reading_t predicted;
    int unsigned   gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    echo_level <= lvl;
    // Hold the transaction until the block takes it
    do begin
      @(posedge clk);
    end while (!in_ready);
    ticks_sent++;
    if (measure_echo_tick(lvl, predicted)) begin
      awaited_readings.push_back(known ? typed : predicted);
    end
  endtask

  // Drop valid, drain all expected readings, then let the block go quiet
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    settle_block();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    reg_writes++;
    case (idx)
      epd_pkg::REG_COUNTER_TOP:  top_cfg   = value[epd_pkg::PULSE_WIDTH-1:0];
      epd_pkg::REG_HALF_SPEED:   speed_cfg = value[epd_pkg::SPEED_WIDTH-1:0];
      epd_pkg::REG_MAX_DISTANCE: limit_cfg = value[epd_pkg::CM_WIDTH-1:0];
      epd_pkg::REG_DUTY_GAIN:    gain_cfg  = value[epd_pkg::CM_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Directed plan rows
  // --------------------------------------------------------------------------
  function automatic plan_row_t ticks(input logic lvl, input int unsigned n);
    plan_row_t row;
    row          = '{default: '0};
    row.level    = lvl;
    row.run      = n;
    return row;
  endfunction

  function automatic plan_row_t known_tick(input logic lvl, input echo_reading_t r);
    plan_row_t row;
    row          = ticks(lvl, 1);
    row.known    = 1'b1;
    row.reading  = r;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input reg_idx_t idx, input logic [15:0] value);
    plan_row_t row;
    row           = '{default: '0};
    row.is_write  = 1'b1;
    row.reg_idx   = idx;
    row.reg_value = value;
    return row;
  endfunction

  plan_row_t plan[$];

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_ticks;
    int unsigned n_low;
    int unsigned n_high;
    int unsigned pick;

    // Reset settings: a one-tick pulse
    plan.push_back(ticks(1'b0, 1));
    plan.push_back(ticks(1'b1, 1));
    plan.push_back(known_tick(1'b0, '{16'd1, 28'd1114, 1'b1, 16'd900}));
    // Full speed with a 1 cm limit: widths either side of the limit
    plan.push_back(reg_row(epd_pkg::REG_HALF_SPEED, 16'd4095));
    plan.push_back(reg_row(epd_pkg::REG_MAX_DISTANCE, 16'd1));
    plan.push_back(ticks(1'b0, 1));
    plan.push_back(ticks(1'b1, 16));
    plan.push_back(ticks(1'b0, 1));
    plan.push_back(ticks(1'b1, 17));
    plan.push_back(ticks(1'b0, 1));
    // Widest pulse: rise at count one under a top of one with the count
    // above top, raise top to full scale, fall at count zero across the wrap
    plan.push_back(reg_row(epd_pkg::REG_MAX_DISTANCE, 16'd255));
    plan.push_back(reg_row(epd_pkg::REG_DUTY_GAIN, 16'd255));
    plan.push_back(reg_row(epd_pkg::REG_COUNTER_TOP, 16'd1));
    plan.push_back(ticks(1'b0, 2));
    plan.push_back(ticks(1'b1, 1));
    plan.push_back(reg_row(epd_pkg::REG_COUNTER_TOP, 16'd65535));
    plan.push_back(known_tick(1'b0, '{16'd65535, 28'd268365825, 1'b0, 16'd0}));
    // Top of one again: a zero width, then a one-tick width
    plan.push_back(reg_row(epd_pkg::REG_COUNTER_TOP, 16'd1));
    plan.push_back(ticks(1'b0, 2));
    plan.push_back(ticks(1'b1, 2));
    plan.push_back(known_tick(1'b0, '{16'd0, 28'd0, 1'b1, 16'd65025}));
    plan.push_back(ticks(1'b1, 1));
    plan.push_back(known_tick(1'b0, '{16'd1, 28'd4095, 1'b1, 16'd65025}));
    // All-zero speed, limit and gain
    plan.push_back(reg_row(epd_pkg::REG_HALF_SPEED, 16'd0));
    plan.push_back(reg_row(epd_pkg::REG_MAX_DISTANCE, 16'd0));
    plan.push_back(reg_row(epd_pkg::REG_DUTY_GAIN, 16'd0));
    plan.push_back(reg_row(epd_pkg::REG_COUNTER_TOP, 16'd65535));
    plan.push_back(ticks(1'b1, 5));
    plan.push_back(known_tick(1'b0, '{16'd5, 28'd0, 1'b1, 16'd0}));

    wait (!rst);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        write_reg(plan[i].reg_idx, plan[i].reg_value);
      end else begin
        repeat (plan[i].run) send_tick(plan[i].level, plan[i].known, plan[i].reading);
      end
    end

    // Random pulse trains, one register setting per phase; the first two
    // phases pin the registers to their extremes.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin
          write_reg(epd_pkg::REG_COUNTER_TOP,  16'd1);
          write_reg(epd_pkg::REG_HALF_SPEED,   16'd4095);
          write_reg(epd_pkg::REG_MAX_DISTANCE, 16'd0);
          write_reg(epd_pkg::REG_DUTY_GAIN,    16'd255);
        end
        1: begin
          write_reg(epd_pkg::REG_COUNTER_TOP,  16'd65535);
          write_reg(epd_pkg::REG_HALF_SPEED,   16'd0);
          write_reg(epd_pkg::REG_MAX_DISTANCE, 16'd255);
          write_reg(epd_pkg::REG_DUTY_GAIN,    16'd0);
        end
        2: begin
          // Short counter period with a tight limit: many wraps, mixed range
          write_reg(epd_pkg::REG_COUNTER_TOP,  16'($urandom_range(2, 30)));
          write_reg(epd_pkg::REG_HALF_SPEED,   16'($urandom_range(0, 4095)));
          write_reg(epd_pkg::REG_MAX_DISTANCE, 16'($urandom_range(0, 3)));
          write_reg(epd_pkg::REG_DUTY_GAIN,    16'($urandom_range(0, 255)));
        end
        3: begin
          write_reg(epd_pkg::REG_COUNTER_TOP,  16'($urandom_range(20, 300)));
          write_reg(epd_pkg::REG_HALF_SPEED,   16'($urandom_range(2000, 4095)));
          write_reg(epd_pkg::REG_MAX_DISTANCE, 16'($urandom_range(0, 8)));
          write_reg(epd_pkg::REG_DUTY_GAIN,    16'($urandom_range(0, 255)));
        end
        default: begin
          write_reg(epd_pkg::REG_COUNTER_TOP,  16'($urandom_range(1, 65535)));
          write_reg(epd_pkg::REG_HALF_SPEED,   16'($urandom_range(0, 4095)));
          write_reg(epd_pkg::REG_MAX_DISTANCE, 16'($urandom_range(0, 255)));
          write_reg(epd_pkg::REG_DUTY_GAIN,    16'($urandom_range(0, 255)));
        end
      endcase

      phase_ticks = 0;
      while (phase_ticks < TICKS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 85) begin
          // Well-formed pulse: a low run, then a high run of random length
          n_low = $urandom_range(1, 4);
          pick  = $urandom_range(0, 19);
          if (pick < 15)      n_high = $urandom_range(1, 10);
          else if (pick < 19) n_high = $urandom_range(11, 120);
          else                n_high = $urandom_range(121, 400);
          repeat (n_low)  send_tick(1'b0, 1'b0, '0);
          repeat (n_high) send_tick(1'b1, 1'b0, '0);
          phase_ticks += n_low + n_high;
        end else begin
          // Noise: short run of random levels
          repeat ($urandom_range(1, 6)) begin
            send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
            phase_ticks++;
          end
        end
      end
    end

    // Drain and let any late transaction show up before judging
    settle_block();

    $display("Run covered %0d ticks, %0d register writes, %0d pulse readings",
             ticks_sent, reg_writes, readings_seen);
    $display("Readings: %0d within limit, %0d beyond, %0d across the counter wrap",
             near_readings, far_readings, wrapped_pulses);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d readings still expected", awaited_readings.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[echo_pulse_ranging_to_duty.f]
hw/rtl/epd_pkg.sv
hw/rtl/epd_datapath.sv
hw/rtl/epd_controller.sv
hw/rtl/echo_pulse_ranging_to_duty.sv
hw/rtl/epd_checker.sv
tb/echo_pulse_ranging_to_duty_test.sv
